>>> sv/lfu_pkg.sv
// Shared constants and control types for the LFU cache table.
package lfu_pkg;

	localparam int LFU_CAPACITY   = 16;
	localparam int LFU_COUNT_BITS = 16;
	localparam int KEY_W          = 31;
	localparam int CFG_W          = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic load;      // latch request, clear scan trackers
		logic scan_rd;   // read entry at addr for match / victim scan
		logic sweep_rd;  // read rank at addr for gap close
		logic decide;    // resolve hit / eviction after scan
		logic commit;    // final table writes and result load
	} lfu_cmd_t;

	typedef struct packed {
		logic need_sweep;
	} lfu_status_t;

endpackage

>>> sv/lfu_ctrl.sv
// Request sequencer: scan, rank sweep and commit phases, result handshake.
module lfu_ctrl import lfu_pkg::*; #(
	parameter int CAPACITY = LFU_CAPACITY,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  lfu_status_t      status,
	output lfu_cmd_t         cmd,
	output logic [IDX_W-1:0] addr
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_SCAN      = 3'd1;
	localparam logic [2:0] S_SCAN_END  = 3'd2;
	localparam logic [2:0] S_DECIDE    = 3'd3;
	localparam logic [2:0] S_SWEEP     = 3'd4;
	localparam logic [2:0] S_SWEEP_END = 3'd5;
	localparam logic [2:0] S_COMMIT    = 3'd6;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign addr      = idx_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					idx_d    = '0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				idx_d = idx_q + 1'b1;
				if (idx_q == IDX_LAST) begin
					idx_d   = '0;
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = S_DECIDE;
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = status.need_sweep ? S_SWEEP : S_COMMIT;
			end
			S_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				idx_d = idx_q + 1'b1;
				if (idx_q == IDX_LAST) begin
					idx_d   = '0;
					state_d = S_SWEEP_END;
				end
			end
			S_SWEEP_END: state_d = S_COMMIT;
			S_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/lfu_dp.sv
// Entry store, match/victim scan, recency rank sweep and result register.
module lfu_dp import lfu_pkg::*; #(
	parameter int CAPACITY   = LFU_CAPACITY,
	parameter int COUNT_BITS = LFU_COUNT_BITS,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lfu_cmd_t         cmd,
	input  logic [IDX_W-1:0] addr,
	input  logic [CFG_W-1:0] cap,
	input  logic             req_op,
	input  logic [KEY_W-1:0] req_key,
	input  logic [KEY_W-1:0] req_val,
	output lfu_status_t      status,
	output logic             res_hit,
	output logic [KEY_W-1:0] res_rd,
	output logic             res_ev,
	output logic [KEY_W-1:0] res_evk
);

	localparam int N_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = N_W + CFG_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [KEY_W-1:0]      key_mem  [CAPACITY];
	logic [KEY_W-1:0]      val_mem  [CAPACITY];
	logic [COUNT_BITS-1:0] cnt_mem  [CAPACITY];
	logic [IDX_W-1:0]      rank_mem [CAPACITY];

	logic [CAPACITY-1:0] valid_q;
	logic [N_W-1:0]      n_q;

	logic                  op_q;
	logic [KEY_W-1:0]      key_q, val_q;

	logic                  scan_s1, sweep_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [KEY_W-1:0]      key_rd_s1, val_rd_s1;
	logic [COUNT_BITS-1:0] cnt_rd_s1;
	logic [IDX_W-1:0]      rank_rd_s1;

	logic                  found_q, vfound_q, sfound_q;
	logic [IDX_W-1:0]      fidx_q, frank_q, vidx_q, vrank_q, sidx_q;
	logic [COUNT_BITS-1:0] fcnt_q, vcnt_q;
	logic [KEY_W-1:0]      fval_q, vkey_q;

	logic                  evict_q;
	logic [IDX_W-1:0]      gap_q, ins_idx_q;

	logic                  hit_r_q, ev_r_q;
	logic [KEY_W-1:0]      rd_r_q, evk_r_q;

	logic             full, ent_v, better;
	logic             rank_we;
	logic [IDX_W-1:0] rank_wa, rank_wd;

	// cap of 0 acts as 1, above CAPACITY acts as CAPACITY
	always_comb begin
		if (cap == '0)
			full = (n_q != '0);
		else
			full = (CMP_W'(cap) <= CMP_W'(n_q)) || (n_q == N_W'(CAPACITY));
	end

	assign status.need_sweep = found_q || (op_q == OP_PUT && full);

	assign ent_v  = valid_q[idx_s1];
	assign better = !vfound_q || (cnt_rd_s1 < vcnt_q) ||
		(cnt_rd_s1 == vcnt_q && rank_rd_s1 < vrank_q);

	always_comb begin
		rank_we = 1'b0;
		rank_wa = idx_s1;
		rank_wd = rank_rd_s1 - 1'b1;
		if (sweep_s1 && ent_v && rank_rd_s1 > gap_q)
			rank_we = 1'b1;
		else if (cmd.commit && found_q) begin
			rank_we = 1'b1;
			rank_wa = fidx_q;
			rank_wd = IDX_W'(n_q - 1'b1);
		end else if (cmd.commit && op_q == OP_PUT) begin
			rank_we = 1'b1;
			rank_wa = ins_idx_q;
			rank_wd = IDX_W'(n_q);
		end
	end

	// memories: one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.sweep_rd)
			rank_rd_s1 <= rank_mem[addr];
		if (cmd.scan_rd) begin
			key_rd_s1 <= key_mem[addr];
			val_rd_s1 <= val_mem[addr];
			cnt_rd_s1 <= cnt_mem[addr];
		end
		if (rank_we)
			rank_mem[rank_wa] <= rank_wd;
		if (cmd.commit && found_q) begin
			cnt_mem[fidx_q] <= (fcnt_q == CNT_MAX) ? fcnt_q : fcnt_q + 1'b1;
			if (op_q == OP_PUT)
				val_mem[fidx_q] <= val_q;
		end else if (cmd.commit && op_q == OP_PUT) begin
			key_mem[ins_idx_q] <= key_q;
			val_mem[ins_idx_q] <= val_q;
			cnt_mem[ins_idx_q] <= COUNT_BITS'(1);
		end
	end

	// request, trackers and result payload
	always_ff @(posedge clk) begin
		idx_s1 <= addr;
		if (cmd.load) begin
			op_q  <= req_op;
			key_q <= req_key;
			val_q <= req_val;
		end
		if (scan_s1) begin
			if (ent_v && key_rd_s1 == key_q) begin
				fidx_q  <= idx_s1;
				fcnt_q  <= cnt_rd_s1;
				frank_q <= rank_rd_s1;
				fval_q  <= val_rd_s1;
			end
			if (ent_v && better) begin
				vidx_q  <= idx_s1;
				vcnt_q  <= cnt_rd_s1;
				vrank_q <= rank_rd_s1;
				vkey_q  <= key_rd_s1;
			end
			if (!ent_v && !sfound_q)
				sidx_q <= idx_s1;
		end
		if (cmd.decide) begin
			gap_q <= found_q ? frank_q : vrank_q;
			if (op_q == OP_PUT && full && !found_q)
				ins_idx_q <= (sfound_q && sidx_q < vidx_q) ? sidx_q : vidx_q;
			else
				ins_idx_q <= sidx_q;
		end
		if (cmd.commit) begin
			hit_r_q <= found_q;
			rd_r_q  <= (found_q && op_q == OP_GET) ? fval_q : '0;
			ev_r_q  <= evict_q;
			evk_r_q <= evict_q ? vkey_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			n_q      <= '0;
			scan_s1  <= 1'b0;
			sweep_s1 <= 1'b0;
			found_q  <= 1'b0;
			vfound_q <= 1'b0;
			sfound_q <= 1'b0;
			evict_q  <= 1'b0;
		end else begin
			scan_s1  <= cmd.scan_rd;
			sweep_s1 <= cmd.sweep_rd;
			if (cmd.load) begin
				found_q  <= 1'b0;
				vfound_q <= 1'b0;
				sfound_q <= 1'b0;
				evict_q  <= 1'b0;
			end
			if (scan_s1) begin
				if (ent_v && key_rd_s1 == key_q)
					found_q <= 1'b1;
				if (ent_v)
					vfound_q <= 1'b1;
				if (!ent_v)
					sfound_q <= 1'b1;
			end
			if (cmd.decide && op_q == OP_PUT && full && !found_q && vfound_q) begin
				evict_q         <= 1'b1;
				valid_q[vidx_q] <= 1'b0;
				n_q             <= n_q - 1'b1;
			end
			if (cmd.commit && !found_q && op_q == OP_PUT) begin
				valid_q[ins_idx_q] <= 1'b1;
				n_q                <= n_q + 1'b1;
			end
		end
	end

	assign res_hit = hit_r_q;
	assign res_rd  = rd_r_q;
	assign res_ev  = ev_r_q;
	assign res_evk = evk_r_q;

endmodule

>>> sv/lfu_cache_table.sv
// LFU cache table top level: stream ports, capacity register, assertions.
// Each request first makes a pass over all entry slots to find the match,
// the victim (lowest use count, oldest among equals) and the first free slot.
// A second pass over the recency-rank memory closes the gap left by the
// touched or evicted entry. Get misses and put misses into a non-full table
// skip the second pass. Every entry store is a single-write-port memory with
// a registered read port, so each pass handles one entry per cycle. One
// request is in flight at a time. The controller returns to idle on the
// clock edge that loads the result into the output register, so the next
// request can be accepted while that result waits. A result that is still
// waiting in the output register holds the next request in its commit state
// until the receiver takes it.
module lfu_cache_table import lfu_pkg::*; #(
	parameter int CAPACITY   = LFU_CAPACITY,
	parameter int COUNT_BITS = LFU_COUNT_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,   // capacity_in_use
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,     // opcode, lookup_key, write_value, pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata      // hit, read_value, evicted, evicted_key
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [CFG_W-1:0] cap_q;
	lfu_cmd_t         cmd;
	lfu_status_t      status;
	logic [IDX_W-1:0] addr;
	logic             res_hit, res_ev;
	logic [KEY_W-1:0] res_rd, res_evk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_q <= CFG_RESET;
		else if (cfg_we)
			cap_q <= cfg_wdata;
	end

	lfu_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.rsp_valid(m_tvalid),
		.rsp_ready(m_tready),
		.status   (status),
		.cmd      (cmd),
		.addr     (addr)
	);

	lfu_dp #(.CAPACITY(CAPACITY), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.addr   (addr),
		.cap    (cap_q),
		.req_op (s_tdata[0]),
		.req_key(s_tdata[31:1]),
		.req_val(s_tdata[62:32]),
		.status (status),
		.res_hit(res_hit),
		.res_rd (res_rd),
		.res_ev (res_ev),
		.res_evk(res_evk)
	);

	assign m_tdata = {res_evk, res_ev, res_rd, res_hit};

	// a request is never taken back to back: the scan follows
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted during scan");

	// an eviction only comes from a miss
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[32]))
		else $error("hit and eviction in one result");

	// read data only on a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:1] != '0 |-> m_tdata[0])
		else $error("read value without hit");

	// evicted key only with eviction flag
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[32] |-> m_tdata[63:33] == '0)
		else $error("evicted key without eviction");

endmodule
